// File: rtl/jet_pkg.sv
// Shared types and constants for the escape-time counter.
// Used by the controller, the datapath and the top level; depends on nothing else.
package jet_pkg;

    localparam int IN_W      = 31;
    localparam int Z_W       = 32;
    localparam int PROD_W    = 2 * Z_W;
    localparam int SUM_W     = 38;
    localparam int CNT_W     = 8;
    localparam int FRAC_BITS = 28;
    localparam int IDX_W     = 1;

    localparam logic [CNT_W-1:0] MAX_STEPS = CNT_W'(255);
    localparam logic signed [SUM_W-1:0] BOUND = SUM_W'(4) <<< FRAC_BITS;

    localparam logic [IDX_W-1:0] REG_C_RE = 1'b0;
    localparam logic [IDX_W-1:0] REG_C_IM = 1'b1;

    typedef enum logic [1:0] {
        MUL_RR,
        MUL_II,
        MUL_RI
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        mul_op_t mul_op;
        logic    latch_rr;
        logic    latch_ii;
        logic    latch_res;
        logic    update;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic escape;
        logic step_zero;
        logic step_max;
    } status_t;

    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] x);
        logic signed [Z_W-1:0] r;
        if ((&x[SUM_W-1:Z_W-1]) || !(|x[SUM_W-1:Z_W-1])) begin
            r = x[Z_W-1:0];
        end else if (x[SUM_W-1]) begin
            r = {1'b1, {(Z_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(Z_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: rtl/jet_datapath.sv
// Datapath: z registers, the shared signed multiplier, the step counter and the result register.
// Depends on jet_pkg for widths, command and status types and the saturation function.
module jet_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  jet_pkg::cmd_t                      cmd,
    output jet_pkg::status_t                   status,
    input  logic signed [jet_pkg::IN_W-1:0]    z0_re,
    input  logic signed [jet_pkg::IN_W-1:0]    z0_im,
    input  logic                               wr_en,
    input  logic        [jet_pkg::IDX_W-1:0]   wr_index,
    input  logic        [jet_pkg::IN_W-1:0]    wr_data,
    output logic        [jet_pkg::CNT_W-1:0]   escape_count
);
    import jet_pkg::*;

    logic signed [IN_W-1:0]   c_re_reg;
    logic signed [IN_W-1:0]   c_im_reg;
    logic signed [Z_W-1:0]    z_re_reg;
    logic signed [Z_W-1:0]    z_im_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [SUM_W-1:0]  rr_reg;
    logic signed [SUM_W-1:0]  ii_reg;
    logic        [CNT_W-1:0]  step_reg;
    logic        [CNT_W-1:0]  res_reg;
    logic        [CNT_W-1:0]  res_next;
    logic        [CNT_W-1:0]  count_reg;
    logic signed [Z_W-1:0]    mul_a;
    logic signed [Z_W-1:0]    mul_b;
    logic signed [PROD_W-1:0] sq_shift;
    logic signed [PROD_W-1:0] cross_shift;
    logic signed [SUM_W-1:0]  sq_now;
    logic signed [SUM_W-1:0]  cross_now;
    logic signed [SUM_W-1:0]  esc_sum;
    logic signed [SUM_W-1:0]  re_sum;
    logic signed [SUM_W-1:0]  im_sum;

    always_comb
    begin
        case (cmd.mul_op)
            MUL_RR:
            begin
                mul_a = z_re_reg;
                mul_b = z_re_reg;
            end
            MUL_II:
            begin
                mul_a = z_im_reg;
                mul_b = z_im_reg;
            end
            default:
            begin
                mul_a = z_re_reg;
                mul_b = z_im_reg;
            end
        endcase
    end

    assign prod_next   = mul_a * mul_b;
    assign sq_shift    = prod_reg >>> FRAC_BITS;
    assign cross_shift = prod_reg >>> (FRAC_BITS - 1);
    assign sq_now      = sq_shift[SUM_W-1:0];
    assign cross_now   = cross_shift[SUM_W-1:0];
    assign esc_sum     = rr_reg + sq_now;
    assign re_sum      = rr_reg - ii_reg + SUM_W'(c_re_reg);
    assign im_sum      = cross_now + SUM_W'(c_im_reg);

    assign status.escape    = esc_sum > BOUND;
    assign status.step_zero = (step_reg == '0);
    assign status.step_max  = (step_reg == MAX_STEPS);

    assign res_next = (status.escape && !status.step_zero) ? step_reg - CNT_W'(1) : MAX_STEPS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            c_re_reg <= '0;
            c_im_reg <= '0;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_C_RE: c_re_reg <= wr_data;
                REG_C_IM: c_im_reg <= wr_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            z_re_reg <= Z_W'(z0_re);
            z_im_reg <= Z_W'(z0_im);
            step_reg <= '0;
        end else if (cmd.update) begin
            z_re_reg <= sat_z(re_sum);
            z_im_reg <= sat_z(im_sum);
            step_reg <= step_reg + CNT_W'(1);
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.latch_rr) begin
            rr_reg <= sq_now;
        end
        if (cmd.latch_ii) begin
            ii_reg <= sq_now;
        end
        if (cmd.latch_res) begin
            res_reg <= res_next;
        end
        if (cmd.load_out) begin
            count_reg <= res_reg;
        end
    end

    assign escape_count = count_reg;

endmodule

// File: rtl/jet_ctrl.sv
// Controller: sequences the square, test, cross-product and update phases of each iteration.
// Depends on jet_pkg for the command and status types.
module jet_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  jet_pkg::status_t status,
    output jet_pkg::cmd_t    cmd
);
    import jet_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_RR,
        S_MUL_II,
        S_TEST,
        S_MUL_RI,
        S_UPDATE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   finish;

    assign finish = (status.escape && !status.step_zero) || status.step_max;

    always_comb
    begin
        cmd            = '0;
        cmd.mul_op     = MUL_RR;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_RR;
                end
            end
            S_MUL_RR:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_RR;
                state_next = S_MUL_II;
            end
            S_MUL_II:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_op   = MUL_II;
                cmd.latch_rr = 1'b1;
                state_next   = S_TEST;
            end
            S_TEST:
            begin
                cmd.latch_ii = 1'b1;
                if (finish) begin
                    cmd.latch_res = 1'b1;
                    state_next    = S_DONE;
                end else begin
                    state_next = S_MUL_RI;
                end
            end
            S_MUL_RI:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_RI;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_MUL_RR;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/julia_escape_time.sv
// Top level of the escape-time counter: joins the controller and the datapath.
// Depends on jet_pkg, jet_ctrl and jet_datapath.
//
// Each input transaction carries a starting point z0 in signed Q3.28; the block iterates
// z = z*z + c on one shared 32x32 multiplier and returns one less than the step index at
// which |z|^2 first exceeds 4 (an escape at step zero is not counted), or 255 if it never
// does. Each iteration computes the two squares on that multiplier, then the escape test,
// then the cross product and the update. A finished point stays in the block while the
// previous result still waits. A new point is taken as soon as the previous result sits
// in the output register, even if that result has not yet been taken. Writing c_re
// (index 0) or c_im (index 1) is allowed only while the block is idle.
module julia_escape_time (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [jet_pkg::IN_W-1:0]    z0_re,
    input  logic signed [jet_pkg::IN_W-1:0]    z0_im,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic        [jet_pkg::CNT_W-1:0]   escape_count,
    input  logic                               wr_en,
    input  logic        [jet_pkg::IDX_W-1:0]   wr_index,
    input  logic        [jet_pkg::IN_W-1:0]    wr_data
);
    import jet_pkg::*;

    cmd_t    cmd;
    status_t status;

    jet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    jet_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .z0_re        (z0_re),
        .z0_im        (z0_im),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .escape_count (escape_count)
    );

    // A point that has been taken keeps the input side closed for the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a point was still being iterated");

    // A fresh result is only presented once the iteration has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result presented while the iteration was still running");

    // No product is latched and z is not updated when the controller is waiting for a new point.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !cmd.mul_en && !cmd.update)
        else $error("datapath active while idle");

endmodule
